// ===== hw/rtl/plp_pkg.sv =====
`timescale 1ns / 1ps
package plp_pkg;

    // number of coordinate axes handled side by side
    localparam int NUM_AXES = 3;

    // axis slots
    localparam int AXIS_X = 0;
    localparam int AXIS_Y = 1;
    localparam int AXIS_Z = 2;

endpackage

// ===== hw/rtl/plp_front.sv =====
`timescale 1ns / 1ps
module plp_front #(
    parameter int C  = 24,
    parameter int LW = 50,
    parameter int SW = 150
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic signed [C-1:0]  a_x,
    input  logic signed [C-1:0]  a_y,
    input  logic signed [C-1:0]  a_z,
    input  logic signed [C-1:0]  b_x,
    input  logic signed [C-1:0]  b_y,
    input  logic signed [C-1:0]  b_z,
    input  logic signed [C-1:0]  r_x,
    input  logic signed [C-1:0]  r_y,
    input  logic signed [C-1:0]  r_z,
    output logic                 out_valid,
    output logic [LW-1:0]        rem,
    output logic [C-1:0]         numlo,
    output logic [LW-1:0]        den,
    output logic [SW-1:0]        side
);
    import plp_pkg::*;

    localparam int DW = C + 1;
    localparam int PW = 2 * C + 2;
    localparam int SUMW = 2 * C + 3;

    logic signed [C-1:0]  a_in [NUM_AXES];
    logic signed [C-1:0]  b_in [NUM_AXES];
    logic signed [C-1:0]  r_in [NUM_AXES];

    logic                 v1_reg, v2_reg, v3_reg, v4_reg;
    logic signed [C-1:0]  p1_reg [NUM_AXES];
    logic signed [DW-1:0] d1_reg [NUM_AXES];
    logic signed [DW-1:0] e1_reg [NUM_AXES];
    logic signed [C-1:0]  p2_reg [NUM_AXES];
    logic signed [DW-1:0] d2_reg [NUM_AXES];
    logic signed [PW-1:0] dd2_reg [NUM_AXES];
    logic signed [PW-1:0] de2_reg [NUM_AXES];
    logic signed [C-1:0]  p3_reg [NUM_AXES];
    logic signed [DW-1:0] d3_reg [NUM_AXES];
    logic signed [SUMW-1:0] len3_reg, dot3_reg;

    logic signed [SUMW-1:0] len3_next, dot3_next;
    logic [SUMW-1:0]      dmag;
    logic [LW-1:0]        rem_next;
    logic                 tneg_next, ovf_next, deg_next;
    logic [LW-1:0]        rem_reg, den_reg;
    logic [C-1:0]         numlo_reg;
    logic [SW-1:0]        side_reg, side_next;

    assign a_in[AXIS_X] = a_x;
    assign a_in[AXIS_Y] = a_y;
    assign a_in[AXIS_Z] = a_z;
    assign b_in[AXIS_X] = b_x;
    assign b_in[AXIS_Y] = b_y;
    assign b_in[AXIS_Z] = b_z;
    assign r_in[AXIS_X] = r_x;
    assign r_in[AXIS_Y] = r_y;
    assign r_in[AXIS_Z] = r_z;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    // differences, products, sums
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < NUM_AXES; i++)
        begin
            p1_reg[i]  <= a_in[i];
            d1_reg[i]  <= {b_in[i][C-1], b_in[i]} - {a_in[i][C-1], a_in[i]};
            e1_reg[i]  <= {r_in[i][C-1], r_in[i]} - {a_in[i][C-1], a_in[i]};
            p2_reg[i]  <= p1_reg[i];
            d2_reg[i]  <= d1_reg[i];
            dd2_reg[i] <= d1_reg[i] * d1_reg[i];
            de2_reg[i] <= d1_reg[i] * e1_reg[i];
            p3_reg[i]  <= p2_reg[i];
            d3_reg[i]  <= d2_reg[i];
        end
        len3_reg <= len3_next;
        dot3_reg <= dot3_next;
    end

    always_comb
    begin
        len3_next = '0;
        dot3_next = '0;
        for (int i = 0; i < NUM_AXES; i++)
        begin
            len3_next = len3_next + SUMW'(dd2_reg[i]);
            dot3_next = dot3_next + SUMW'(de2_reg[i]);
        end
    end

    // divider setup: upper part of |dot| seeds the remainder
    always_comb
    begin
        tneg_next = dot3_reg[SUMW-1];
        dmag      = tneg_next ? (~dot3_reg + 1'b1) : dot3_reg;
        rem_next  = LW'(dmag[LW-1:C]);
        ovf_next  = rem_next >= len3_reg[LW-1:0];
        deg_next  = (len3_reg == '0);
        side_next = {p3_reg[AXIS_X], p3_reg[AXIS_Y], p3_reg[AXIS_Z],
                     d3_reg[AXIS_X], d3_reg[AXIS_Y], d3_reg[AXIS_Z],
                     deg_next, tneg_next, ovf_next};
    end

    always_ff @(posedge clk)
    begin
        rem_reg   <= rem_next;
        den_reg   <= len3_reg[LW-1:0];
        numlo_reg <= dmag[C-1:0];
        side_reg  <= side_next;
    end

    assign out_valid = v4_reg;
    assign rem       = rem_reg;
    assign den       = den_reg;
    assign numlo     = numlo_reg;
    assign side      = side_reg;

endmodule

// ===== hw/rtl/plp_div_stage.sv =====
`timescale 1ns / 1ps
module plp_div_stage #(
    parameter int C  = 24,
    parameter int LW = 50,
    parameter int TW = 40,
    parameter int SW = 150
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic [LW-1:0] in_rem,
    input  logic [C-1:0]  in_numlo,
    input  logic [LW-1:0] in_den,
    input  logic [TW-1:0] in_q,
    input  logic [SW-1:0] in_side,
    output logic          out_valid,
    output logic [LW-1:0] out_rem,
    output logic [C-1:0]  out_numlo,
    output logic [LW-1:0] out_den,
    output logic [TW-1:0] out_q,
    output logic [SW-1:0] out_side
);
    import plp_pkg::*;

    logic [LW:0]   sh;
    logic          qbit;
    logic [LW-1:0] rem_next;
    logic          valid_reg;
    logic [LW-1:0] rem_reg, den_reg;
    logic [C-1:0]  numlo_reg;
    logic [TW-1:0] q_reg;
    logic [SW-1:0] side_reg;

    // one restoring step: bring down the next numerator bit
    always_comb
    begin
        sh       = {in_rem, in_numlo[C-1]};
        qbit     = sh >= {1'b0, in_den};
        rem_next = qbit ? LW'(sh - {1'b0, in_den}) : sh[LW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        rem_reg   <= rem_next;
        den_reg   <= in_den;
        numlo_reg <= {in_numlo[C-2:0], 1'b0};
        q_reg     <= {in_q[TW-2:0], qbit};
        side_reg  <= in_side;
    end

    assign out_valid = valid_reg;
    assign out_rem   = rem_reg;
    assign out_den   = den_reg;
    assign out_numlo = numlo_reg;
    assign out_q     = q_reg;
    assign out_side  = side_reg;

endmodule

// ===== hw/rtl/plp_back.sv =====
`timescale 1ns / 1ps
module plp_back #(
    parameter int C  = 24,
    parameter int F  = 16,
    parameter int TW = 40,
    parameter int SW = 150
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic [TW-1:0]       in_q,
    input  logic [SW-1:0]       in_side,
    output logic                out_valid,
    output logic signed [C-1:0] foot_x,
    output logic signed [C-1:0] foot_y,
    output logic signed [C-1:0] foot_z,
    output logic                degenerate,
    output logic                saturated
);
    import plp_pkg::*;

    localparam int DW = C + 1;
    localparam int L  = TW / 2;
    localparam int H  = TW - L;
    localparam int AW = C + 1 + TW;
    localparam int MW = AW + 1;
    localparam int OW = MW + 1 - F;
    localparam int FW = OW + 1;
    localparam logic [MW:0] HALF = {{(MW - F + 1){1'b0}}, 1'b1, {(F - 1){1'b0}}};
    localparam logic signed [FW-1:0] HI_LIM = FW'((64'sd1 <<< (C - 1)) - 64'sd1);
    localparam logic signed [FW-1:0] LO_LIM = FW'(-(64'sd1 <<< (C - 1)));

    logic signed [C-1:0]  p_in [NUM_AXES];
    logic signed [DW-1:0] d_in [NUM_AXES];
    logic                 deg_in, tneg_in, ovf_in;
    logic [TW-1:0]        tmag;

    logic                 v1_reg, v2_reg, v3_reg;
    logic signed [C-1:0]  p1_reg [NUM_AXES];
    logic signed [C-1:0]  p2_reg [NUM_AXES];
    logic [C+H:0]         phi1_reg [NUM_AXES];
    logic [C+L:0]         plo1_reg [NUM_AXES];
    logic                 neg1_reg [NUM_AXES];
    logic signed [MW-1:0] prod2_reg [NUM_AXES];
    logic                 deg1_reg, deg2_reg, ovf1_reg, ovf2_reg;

    logic [DW-1:0]        dmag [NUM_AXES];
    logic [AW-1:0]        mag [NUM_AXES];
    logic signed [C-1:0]  foot_next [NUM_AXES];
    logic                 sat_next;
    logic signed [MW:0]   rsum;
    logic signed [FW-1:0] f;

    logic signed [C-1:0]  foot_reg [NUM_AXES];
    logic                 deg_reg, sat_reg;

    always_comb
    begin
        {p_in[AXIS_X], p_in[AXIS_Y], p_in[AXIS_Z],
         d_in[AXIS_X], d_in[AXIS_Y], d_in[AXIS_Z],
         deg_in, tneg_in, ovf_in} = in_side;
        tmag = ovf_in ? {TW{1'b1}} : in_q;
        for (int i = 0; i < NUM_AXES; i++)
            dmag[i] = d_in[i][C] ? (~d_in[i] + 1'b1) : d_in[i];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // partial products of |t| * |d|, then recombine with sign
    always_comb
    begin
        for (int i = 0; i < NUM_AXES; i++)
        begin
            mag[i] = {phi1_reg[i], {L{1'b0}}} + AW'(plo1_reg[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < NUM_AXES; i++)
        begin
            phi1_reg[i]  <= dmag[i] * tmag[TW-1:L];
            plo1_reg[i]  <= dmag[i] * tmag[L-1:0];
            neg1_reg[i]  <= tneg_in ^ d_in[i][C];
            p1_reg[i]    <= p_in[i];
            p2_reg[i]    <= p1_reg[i];
            prod2_reg[i] <= neg1_reg[i] ? -$signed({1'b0, mag[i]}) : $signed({1'b0, mag[i]});
            foot_reg[i]  <= foot_next[i];
        end
        deg1_reg <= deg_in;
        ovf1_reg <= ovf_in;
        deg2_reg <= deg1_reg;
        ovf2_reg <= ovf1_reg;
        deg_reg  <= deg2_reg;
        sat_reg  <= sat_next;
    end

    // round, offset from the first point, clip; a degenerate line yields the first point
    always_comb
    begin
        sat_next = ovf2_reg;
        rsum     = '0;
        f        = '0;
        for (int i = 0; i < NUM_AXES; i++)
        begin
            rsum = {prod2_reg[i][MW-1], prod2_reg[i]} + $signed(HALF);
            f    = FW'(p2_reg[i]) + FW'($signed(rsum[MW:F]));
            if (f > HI_LIM)
            begin
                foot_next[i] = HI_LIM[C-1:0];
                sat_next     = 1'b1;
            end
            else if (f < LO_LIM)
            begin
                foot_next[i] = LO_LIM[C-1:0];
                sat_next     = 1'b1;
            end
            else
            begin
                foot_next[i] = f[C-1:0];
            end
        end
        if (deg2_reg)
        begin
            sat_next = 1'b0;
            for (int i = 0; i < NUM_AXES; i++)
                foot_next[i] = p2_reg[i];
        end
    end

    assign out_valid  = v3_reg;
    assign foot_x     = foot_reg[AXIS_X];
    assign foot_y     = foot_reg[AXIS_Y];
    assign foot_z     = foot_reg[AXIS_Z];
    assign degenerate = deg_reg;
    assign saturated  = sat_reg;

endmodule

// ===== hw/rtl/point_line_projection_3d.sv =====
`timescale 1ns / 1ps
// point_line_projection_3d: foot of the perpendicular from a query point to a line
//
// request channel: pulse start with line_a_*, line_b_* and query_* valid; the
// request is taken at any edge where start is high and busy is low. busy is
// always low, so a new request may enter on every clock.
// result channel: done is high for exactly one cycle with foot_*, degenerate
// and saturated; the result must be captured in that cycle.
// path: an accepted request passes the front stages, the long divider for t (one
// quotient bit per stage) and the back stages before done.
// throughput: one request per cycle, fully pipelined.
// reset: rst_n clears all stage valid bits; requests in flight are dropped
// and no done pulse is issued until new requests arrive.
// results come out in request order; there is no backpressure.
module point_line_projection_3d #(
    parameter int COORD_BITS  = 24,
    parameter int T_FRAC_BITS = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic signed [COORD_BITS-1:0] line_a_x,
    input  logic signed [COORD_BITS-1:0] line_a_y,
    input  logic signed [COORD_BITS-1:0] line_a_z,
    input  logic signed [COORD_BITS-1:0] line_b_x,
    input  logic signed [COORD_BITS-1:0] line_b_y,
    input  logic signed [COORD_BITS-1:0] line_b_z,
    input  logic signed [COORD_BITS-1:0] query_x,
    input  logic signed [COORD_BITS-1:0] query_y,
    input  logic signed [COORD_BITS-1:0] query_z,
    output logic                         done,
    output logic signed [COORD_BITS-1:0] foot_x,
    output logic signed [COORD_BITS-1:0] foot_y,
    output logic signed [COORD_BITS-1:0] foot_z,
    output logic                         degenerate,
    output logic                         saturated
);
    import plp_pkg::*;

    localparam int C   = COORD_BITS;
    localparam int TW  = COORD_BITS + T_FRAC_BITS;   // quotient bits of t
    localparam int LW  = 2 * COORD_BITS + 2;         // |d|^2 width
    localparam int SW  = NUM_AXES * (2 * COORD_BITS + 1) + 3;
    localparam int LAT = TW + 7;

    // divider chain buses, one slot per stage boundary
    logic          dv    [TW+1];
    logic [LW-1:0] drem  [TW+1];
    logic [C-1:0]  dnum  [TW+1];
    logic [LW-1:0] dden  [TW+1];
    logic [TW-1:0] dq    [TW+1];
    logic [SW-1:0] dside [TW+1];

    logic          accept;

    assign busy   = 1'b0;
    assign accept = start & ~busy;
    assign dq[0]  = '0;

    // differences, dot products, divider seed
    plp_front #(.C(C), .LW(LW), .SW(SW)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept),
        .a_x       (line_a_x),
        .a_y       (line_a_y),
        .a_z       (line_a_z),
        .b_x       (line_b_x),
        .b_y       (line_b_y),
        .b_z       (line_b_z),
        .r_x       (query_x),
        .r_y       (query_y),
        .r_z       (query_z),
        .out_valid (dv[0]),
        .rem       (drem[0]),
        .numlo     (dnum[0]),
        .den       (dden[0]),
        .side      (dside[0])
    );

    // restoring divider, one quotient bit per stage
    for (genvar k = 0; k < TW; k++)
    begin : g_div
        plp_div_stage #(.C(C), .LW(LW), .TW(TW), .SW(SW)) u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (dv[k]),
            .in_rem    (drem[k]),
            .in_numlo  (dnum[k]),
            .in_den    (dden[k]),
            .in_q      (dq[k]),
            .in_side   (dside[k]),
            .out_valid (dv[k+1]),
            .out_rem   (drem[k+1]),
            .out_numlo (dnum[k+1]),
            .out_den   (dden[k+1]),
            .out_q     (dq[k+1]),
            .out_side  (dside[k+1])
        );
    end

    // t * d, rounding, clipping
    plp_back #(.C(C), .F(T_FRAC_BITS), .TW(TW), .SW(SW)) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (dv[TW]),
        .in_q       (dq[TW]),
        .in_side    (dside[TW]),
        .out_valid  (done),
        .foot_x     (foot_x),
        .foot_y     (foot_y),
        .foot_z     (foot_z),
        .degenerate (degenerate),
        .saturated  (saturated)
    );

`ifndef ASSERT_OFF
    // every result traces back to an accepted request earlier in the pipeline
    a_done_latency: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, LAT))
        else $error("result without matching request");

    // a coincident line never reports clipping
    a_deg_no_sat: assert property (@(posedge clk) disable iff (!rst_n)
        done && degenerate |-> !saturated)
        else $error("degenerate result flagged saturated");

    // a coincident line returns the first point (checked on x and z)
    a_deg_foot: assert property (@(posedge clk) disable iff (!rst_n)
        done && degenerate |-> foot_x == $past(line_a_x, LAT)
                            && foot_z == $past(line_a_z, LAT))
        else $error("degenerate foot differs from first point");
`endif

endmodule
